/* design/vlam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlam_pkg
// shared types, codes and limit profiles of the vital limit alarm monitor
// ----------------------------------------------------------------------------
package vlam_pkg;

    localparam int NUM_CH   = 5;
    localparam int NUM_PROF = 3;

    typedef logic signed [15:0] t_val;
    typedef logic [1:0]         t_cmd;
    typedef logic [1:0]         t_side;
    typedef logic [1:0]         t_urg;
    typedef logic [2:0]         t_id;

    localparam t_cmd CMD_SAMPLE  = 2'd0;
    localparam t_cmd CMD_SET_LOW = 2'd1;
    localparam t_cmd CMD_SET_HI  = 2'd2;
    localparam t_cmd CMD_PROFILE = 2'd3;

    localparam t_side SIDE_NONE = 2'd0;
    localparam t_side SIDE_LOW  = 2'd1;
    localparam t_side SIDE_HIGH = 2'd2;

    localparam t_urg URG_NONE = 2'd0;
    localparam t_urg URG_MED  = 2'd1;
    localparam t_urg URG_HIGH = 2'd2;

    localparam t_id ID_PRESSURE = 3'd4;
    localparam t_id ID_NONE     = 3'd5;

    // word widths on the stream ports
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // per profile, per channel limits
    localparam t_val PROF_LOW [0:NUM_PROF-1][0:NUM_CH-1] = '{
        '{16'sd50,  16'sd90, 16'sd350, 16'sd8,  16'sd90},
        '{16'sd70,  16'sd92, 16'sd355, 16'sd15, 16'sd80},
        '{16'sd100, 16'sd88, 16'sd360, 16'sd25, 16'sd55}
    };
    localparam t_val PROF_HIGH [0:NUM_PROF-1][0:NUM_CH-1] = '{
        '{16'sd120, 16'sd100, 16'sd380, 16'sd30, 16'sd160},
        '{16'sd150, 16'sd100, 16'sd380, 16'sd40, 16'sd130},
        '{16'sd190, 16'sd98,  16'sd375, 16'sd60, 16'sd90}
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input word and apply its update
        logic load_out;  // evaluate channels and fill the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } t_dp_status;

endpackage

/* design/vital_limit_alarm_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vital_limit_alarm_monitor
// five-channel window-comparator alarm monitor with limit profiles
// ----------------------------------------------------------------------------
// usage
//   slave stream carries one command word: store a sample, set a low or high
//   limit, or load a built-in limit profile. master stream returns one result
//   word per command: every channel's alarm side, the most urgent alarm, the
//   loaded profile and the addressed channel's limits.
// timing
//   a word is taken in the idle state; the update is applied at that edge,
//   the next cycle evaluates all five channels and fills the output register.
//   the result is valid once the evaluate state has loaded the output register;
//   a new word is not taken until the last one has been evaluated.
// stalls
//   the output register lets the input take a new word while a result waits;
//   if the previous result is still held, evaluation waits and the input stays
//   closed until the result is taken.
// reset
//   synchronous active low: adult limits, samples and valid flags cleared,
//   no result pending.
// ----------------------------------------------------------------------------
module vital_limit_alarm_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command word stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // vital_id[2:0], sample_value[18:3], sample_ok[19], profile_sel[21:20], zero pad
    input  logic [vlam_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                        i_s_axis_tuser,
    // result word stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // side_heart_rate[1:0], side_oxygen[3:2], side_temperature[5:4],
    // side_resp_rate[7:6], side_pressure[9:8], top_vital[12:10],
    // top_urgency[14:13], current_profile[16:15], limit_low_out[32:17],
    // limit_high_out[48:33], zero pad
    output logic [vlam_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // accepted[0]
    output logic                              o_m_axis_tuser
);

    vlam_pkg::t_ctrl_cmd  ctrl_cmd;
    vlam_pkg::t_dp_status dp_stat;

    // sequencer
    vlam_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (dp_stat),
        .o_cmd           (ctrl_cmd)
    );

    // channel state, compares and output register
    vlam_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctrl_cmd),
        .o_stat          (dp_stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

/* design/vlam_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlam_ctrl
// sequencer: accept one word, then evaluate and hand the result to the output
// ----------------------------------------------------------------------------
module vlam_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  vlam_pkg::t_dp_status  i_stat,
    output vlam_pkg::t_ctrl_cmd   o_cmd
);

    vlam_pkg::t_state r_state;
    vlam_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vlam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        case (r_state)
            vlam_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = vlam_pkg::ST_EVAL;
                end
            end
            vlam_pkg::ST_EVAL: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = vlam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vlam_pkg::ST_IDLE;
            end
        endcase
    end

    a_capture_then_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == vlam_pkg::ST_EVAL)
        else $error("capture not followed by evaluation");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("output register overwritten");

    a_eval_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vlam_pkg::ST_EVAL && !i_stat.out_free) |=> r_state == vlam_pkg::ST_EVAL)
        else $error("result dropped during output stall");

    a_no_double_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.load_out))
        else $error("capture and load in one cycle");

endmodule

/* design/vlam_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlam_datapath
// channel state, window compares, priority pick and output register
// ----------------------------------------------------------------------------
module vlam_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vlam_pkg::t_ctrl_cmd                 i_cmd,
    output vlam_pkg::t_dp_status                o_stat,
    input  logic [vlam_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [vlam_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tuser
);

    // input word fields
    vlam_pkg::t_cmd in_cmd;
    vlam_pkg::t_id  in_id;
    vlam_pkg::t_val in_val;
    logic           in_ok;
    logic [1:0]     in_prof;
    logic           in_id_ok;
    logic           in_prof_ok;

    assign in_cmd     = i_s_axis_tuser;
    assign in_id      = i_s_axis_tdata[2:0];
    assign in_val     = i_s_axis_tdata[18:3];
    assign in_ok      = i_s_axis_tdata[19];
    assign in_prof    = i_s_axis_tdata[21:20];
    assign in_id_ok   = in_id < 3'(vlam_pkg::NUM_CH);
    assign in_prof_ok = in_prof < 2'(vlam_pkg::NUM_PROF);

    vlam_pkg::t_val r_low  [0:vlam_pkg::NUM_CH-1];
    vlam_pkg::t_val r_high [0:vlam_pkg::NUM_CH-1];
    vlam_pkg::t_val r_samp [0:vlam_pkg::NUM_CH-1];
    logic [vlam_pkg::NUM_CH-1:0] r_vbit;
    logic [1:0]     r_prof;
    vlam_pkg::t_id  r_id;
    logic           r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vlam_pkg::NUM_CH; i++) begin
                r_low[i]  <= vlam_pkg::PROF_LOW[0][i];
                r_high[i] <= vlam_pkg::PROF_HIGH[0][i];
                r_samp[i] <= '0;
            end
            r_vbit <= '0;
            r_prof <= '0;
        end else if (i_cmd.capture) begin
            if (in_cmd == vlam_pkg::CMD_PROFILE) begin
                if (in_prof_ok) begin
                    r_prof <= in_prof;
                    for (int i = 0; i < vlam_pkg::NUM_CH; i++) begin
                        r_low[i]  <= vlam_pkg::PROF_LOW[in_prof][i];
                        r_high[i] <= vlam_pkg::PROF_HIGH[in_prof][i];
                    end
                end
            end else if (in_id_ok) begin
                case (in_cmd)
                    vlam_pkg::CMD_SAMPLE: begin
                        r_samp[in_id] <= in_val;
                        r_vbit[in_id] <= in_ok;
                    end
                    vlam_pkg::CMD_SET_LOW: r_low[in_id]  <= in_val;
                    vlam_pkg::CMD_SET_HI:  r_high[in_id] <= in_val;
                    default: ;
                endcase
            end
        end
    end

    // item bookkeeping, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id  <= in_id;
            r_acc <= (in_cmd == vlam_pkg::CMD_PROFILE) ? in_prof_ok : in_id_ok;
        end
    end

    // window compares on the updated state
    vlam_pkg::t_side side [0:vlam_pkg::NUM_CH-1];
    vlam_pkg::t_urg  urg  [0:vlam_pkg::NUM_CH-1];
    vlam_pkg::t_id   top_id;
    vlam_pkg::t_urg  top_urg;

    always_comb begin
        for (int i = 0; i < vlam_pkg::NUM_CH; i++) begin
            side[i] = vlam_pkg::SIDE_NONE;
            if (r_vbit[i]) begin
                if (r_samp[i] < r_low[i]) begin
                    side[i] = vlam_pkg::SIDE_LOW;
                end else if (r_samp[i] > r_high[i]) begin
                    side[i] = vlam_pkg::SIDE_HIGH;
                end
            end
            if (side[i] == vlam_pkg::SIDE_NONE) begin
                urg[i] = vlam_pkg::URG_NONE;
            end else if (i < 2) begin
                urg[i] = vlam_pkg::URG_HIGH;
            end else if (i == int'(vlam_pkg::ID_PRESSURE) && side[i] == vlam_pkg::SIDE_LOW) begin
                urg[i] = vlam_pkg::URG_HIGH;
            end else begin
                urg[i] = vlam_pkg::URG_MED;
            end
        end
        // lowest channel wins among equal urgency
        top_id  = vlam_pkg::ID_NONE;
        top_urg = vlam_pkg::URG_NONE;
        for (int i = 0; i < vlam_pkg::NUM_CH; i++) begin
            if (urg[i] > top_urg) begin
                top_urg = urg[i];
                top_id  = 3'(i);
            end
        end
    end

    logic           id_ok;
    vlam_pkg::t_val lim_low;
    vlam_pkg::t_val lim_high;

    assign id_ok    = r_id < 3'(vlam_pkg::NUM_CH);
    assign lim_low  = id_ok ? r_low[r_id]  : '0;
    assign lim_high = id_ok ? r_high[r_id] : '0;

    // output register
    logic r_out_valid;
    logic [vlam_pkg::OUT_DATA_W-1:0] r_out_data;
    logic r_out_acc;

    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_acc  <= r_acc;
            r_out_data <= {7'd0, lim_high, lim_low, r_prof, top_urg, top_id,
                           side[4], side[3], side[2], side[1], side[0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_acc;

endmodule
